// ===== rtl/taylor_poly_horner_eval_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Taylor polynomial Horner evaluator
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TAYLOR_POLY_HORNER_EVAL_CORE_DEFINES_SVH
`define TAYLOR_POLY_HORNER_EVAL_CORE_DEFINES_SVH

// Same-cycle implication
`define TPH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TPH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tph_pkg.sv =====
// ----------------------------------------------------------------------------
// tph_pkg
// Types, widths and the reciprocal table of the Horner evaluator.
// ----------------------------------------------------------------------------
package tph_pkg;

  localparam int X_W      = 32;  // argument and coefficient, Q8.24
  localparam int ACC_W    = 48;  // accumulator and result, Q24.24
  localparam int ORDER_W  = 4;
  localparam int RCP_W    = 31;  // unsigned Q1.30 reciprocal
  localparam int CELL_IDX_W = 3;
  localparam int CFG_IDX_W  = 4;

  // Item travelling down the row of cells
  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic                    ov;
    logic signed [X_W-1:0]   x;
    logic                    mode;
    logic [ORDER_W-1:0]      order;
  } item_t;

  // Mode codes
  localparam logic MODE_DERIV    = 1'b0;
  localparam logic MODE_INTEGRAL = 1'b1;

  // round(2^30 / k) for k = 1 .. 8
  function automatic logic [RCP_W-1:0] recip_q30(input logic [3:0] k);
    logic [RCP_W-1:0] r;
    unique case (k)
      4'd2:    r = 31'd536870912;
      4'd3:    r = 31'd357913941;
      4'd4:    r = 31'd268435456;
      4'd5:    r = 31'd214748365;
      4'd6:    r = 31'd178956971;
      4'd7:    r = 31'd153391689;
      4'd8:    r = 31'd134217728;
      default: r = 31'd1073741824;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/tph_cell.sv =====
// ----------------------------------------------------------------------------
// tph_cell
// One Horner step when the step is active, acc = sat(sat(acc * x / k) + coef),
// else the item passes unchanged; five register stages.
module tph_cell (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic [tph_pkg::CELL_IDX_W-1:0]       cell_idx,
  input  logic signed [tph_pkg::X_W-1:0]       coef,
  input  logic                                 in_v,
  input  tph_pkg::item_t                       in_item,
  output logic                                 out_v,
  output tph_pkg::item_t                       out_item
);

  // Step control
  logic                           act;
  logic [3:0]                     k;
  logic [tph_pkg::ACC_W-1:0]      ua;
  logic [tph_pkg::X_W-1:0]        ux;

  always_comb begin
    if (cell_idx == '0) begin
      act = (in_item.mode == tph_pkg::MODE_INTEGRAL);
      k   = 4'd1;
    end else if (in_item.mode == tph_pkg::MODE_INTEGRAL) begin
      act = 1'b1;
      k   = {1'b0, cell_idx} + 4'd1;
    end else begin
      act = ({1'b0, cell_idx} > in_item.order);
      k   = {1'b0, cell_idx} - in_item.order;
    end
    ua = in_item.acc[tph_pkg::ACC_W-1] ? 48'(-in_item.acc) : 48'(in_item.acc);
    ux = in_item.x[tph_pkg::X_W-1] ? 32'(-in_item.x) : 32'(in_item.x);
  end

  // Stage valids
  logic [4:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_v};
    end
  end

  assign out_v = v_r[4];

  // Stage payloads
  tph_pkg::item_t                   it1_r, it2_r, it3_r, it4_r, it5_r;
  logic                             neg1_r, neg2_r, neg3_r;
  logic                             act1_r, act2_r, act3_r, act4_r;
  logic [tph_pkg::RCP_W-1:0]        rcp1_r, rcp2_r;
  logic [55:0]                      phi_r, plo_r, m_r;
  logic [56:0]                      q1_r;
  logic [60:0]                      q2_r;
  logic signed [tph_pkg::ACC_W-1:0] t_r;
  logic                             tov_r;

  // Scale and saturate the product, then add the coefficient
  logic [57:0]                      q;
  logic signed [58:0]               vq;
  logic signed [tph_pkg::ACC_W-1:0] t_nxt;
  logic                             tov_nxt;
  logic signed [48:0]               sum;
  tph_pkg::item_t                   it5_nxt;

  always_comb begin
    q  = 58'(q1_r) + 58'(q2_r >> 30);
    vq = neg3_r ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (vq[58:47] == {12{vq[58]}}) begin
      t_nxt   = vq[47:0];
      tov_nxt = 1'b0;
    end else begin
      t_nxt   = vq[58] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      tov_nxt = 1'b1;
    end

    sum     = {t_r[47], t_r} + {{17{coef[31]}}, coef};
    it5_nxt = it4_r;
    if (act4_r) begin
      if (sum[48] != sum[47]) begin
        it5_nxt.acc = sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        it5_nxt.ov  = 1'b1;
      end else begin
        it5_nxt.acc = sum[47:0];
        it5_nxt.ov  = it4_r.ov | tov_r;
      end
    end
  end

  // Advance the stages
  always_ff @(posedge clk) begin
    if (en) begin
      // split magnitude product
      it1_r  <= in_item;
      neg1_r <= in_item.acc[tph_pkg::ACC_W-1] ^ in_item.x[tph_pkg::X_W-1];
      act1_r <= act;
      rcp1_r <= tph_pkg::recip_q30(k);
      phi_r  <= 56'(ux) * 56'(ua[47:24]);
      plo_r  <= 56'(ux) * 56'(ua[23:0]);
      // combine to Q32.24 magnitude
      it2_r  <= it1_r;
      neg2_r <= neg1_r;
      act2_r <= act1_r;
      rcp2_r <= rcp1_r;
      m_r    <= phi_r + (plo_r >> 24);
      // reciprocal partial products
      it3_r  <= it2_r;
      neg3_r <= neg2_r;
      act3_r <= act2_r;
      q1_r   <= 57'(m_r[55:30]) * 57'(rcp2_r);
      q2_r   <= 61'(m_r[29:0]) * 61'(rcp2_r);
      // signed, saturated product
      it4_r  <= it3_r;
      act4_r <= act3_r;
      t_r    <= t_nxt;
      tov_r  <= tov_nxt;
      // accumulate
      it5_r  <= it5_nxt;
    end
  end

  assign out_item = it5_r;

endmodule

// ===== rtl/taylor_poly_horner_eval_core.sv =====
// ----------------------------------------------------------------------------
// taylor_poly_horner_eval_core
// Fixed-point Horner evaluator of a Taylor-coefficient polynomial.
// ----------------------------------------------------------------------------
// Usage:
//   Load coef_0 .. coef_(NUM_COEFS-1) (signed Q8.24) through the cfg_ channel
//   while no item is in flight; cfg_ready is always high and writes to
//   higher indices are dropped. Each input item carries arg_x in in_tdata and
//   mode / deriv_order in in_tuser. Mode 0 yields the n-th derivative (n = 0
//   is the plain value, n >= NUM_COEFS yields zero), mode 1 the integral
//   from zero. Each result carries the Q24.24 value in out_tdata and the
//   saturation flag in out_tuser.
//   A row of NUM_COEFS cells of five register stages each does one Horner
//   step per cell; the last cell does the closing multiply by x in mode 1.
//   One item is taken per cycle while in_tready is high.
//   When out_tready is low the result waits in the output register
//   and one further result lands in a skid register; only once that is full
//   does in_tready drop and the whole row hold. Reset clears all
//   coefficients to zero and empties the row and the output.
// ----------------------------------------------------------------------------
`include "taylor_poly_horner_eval_core_defines.svh"

module taylor_poly_horner_eval_core #(
  parameter int NUM_COEFS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input items
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // [31:0] arg_x
  input  logic [4:0]                     in_tuser,   // [0] mode, [4:1] deriv_order
  // result items
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [47:0]                    out_tdata,  // [47:0] value
  output logic [0:0]                     out_tuser,  // [0] overflow
  // coefficient writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tph_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);

  localparam int CI_W = $clog2(NUM_COEFS);

  // Coefficient registers
  logic signed [tph_pkg::X_W-1:0] coef_r [NUM_COEFS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_valid && (cfg_index < tph_pkg::CFG_IDX_W'(NUM_COEFS))) begin
      coef_r[cfg_index[CI_W-1:0]] <= cfg_data;
    end
  end

  // Row advance: hold everything once the skid register is occupied
  logic skid_valid_r;
  logic en;

  assign en        = !skid_valid_r;
  assign in_tready = en;

  // Entry item: accumulator starts as the top coefficient
  logic           v_chain [NUM_COEFS+1];
  tph_pkg::item_t i_chain [NUM_COEFS+1];

  assign v_chain[0] = in_tvalid;
  assign i_chain[0] = '{acc:   {{16{coef_r[NUM_COEFS-1][31]}}, coef_r[NUM_COEFS-1]},
                        ov:    1'b0,
                        x:     in_tdata,
                        mode:  in_tuser[0],
                        order: in_tuser[4:1]};

  // Row of cells, step index NUM_COEFS-1 down to 0
  for (genvar g = 0; g < NUM_COEFS; g++) begin : g_cell
    localparam int IDX = NUM_COEFS - 1 - g;
    logic signed [tph_pkg::X_W-1:0] cell_coef;

    if (IDX > 0) begin : g_coef
      assign cell_coef = coef_r[IDX-1];
    end else begin : g_nocoef
      assign cell_coef = '0;
    end

    tph_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .cell_idx (tph_pkg::CELL_IDX_W'(IDX)),
      .coef     (cell_coef),
      .in_v     (v_chain[g]),
      .in_item  (i_chain[g]),
      .out_v    (v_chain[g+1]),
      .out_item (i_chain[g+1])
    );
  end

  // Final result: force zero for an order beyond the degree
  tph_pkg::item_t last;
  logic           zero_res;
  logic [47:0]    res_value;
  logic           res_ov;
  logic           push;

  always_comb begin
    last      = i_chain[NUM_COEFS];
    zero_res  = (last.mode == tph_pkg::MODE_DERIV) &&
                (last.order >= tph_pkg::ORDER_W'(NUM_COEFS));
    res_value = zero_res ? '0 : last.acc;
    res_ov    = zero_res ? 1'b0 : last.ov;
    push      = en && v_chain[NUM_COEFS];
  end

  // Output register and skid register
  logic        out_valid_r;
  logic [47:0] out_value_r, skid_value_r;
  logic        out_ov_r, skid_ov_r;
  logic        pop;

  assign pop = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || pop) begin
      out_valid_r <= push;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_value_r <= skid_value_r;
        out_ov_r    <= skid_ov_r;
      end
    end else if (!out_valid_r || pop) begin
      out_value_r <= res_value;
      out_ov_r    <= res_ov;
    end else if (push) begin
      skid_value_r <= res_value;
      skid_ov_r    <= res_ov;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_value_r;
  assign out_tuser[0] = out_ov_r;

  // Checks on the output buffering
  `TPH_ASSERT_IMP(a_skid_behind_out, skid_valid_r, out_valid_r,
                  "skid register holds an item while the output register is empty")
  `TPH_ASSERT_NXT(a_skid_kept, skid_valid_r && !out_tready, skid_valid_r,
                  "skid item dropped without the output being taken")
  `TPH_ASSERT_IMP(a_skid_fill, $rose(skid_valid_r), $past(out_valid_r && !out_tready),
                  "skid register filled while the output was free")

endmodule
